>>> rtl/utf8t_pkg.sv
// Shared types, codes and constants for the UTF-8 transcoder.
package utf8t_pkg;

    // Target encodings
    localparam logic [2:0] ENC_UTF8    = 3'd0;
    localparam logic [2:0] ENC_U16LE   = 3'd1;
    localparam logic [2:0] ENC_U16BE   = 3'd2;
    localparam logic [2:0] ENC_U32LE   = 3'd3;
    localparam logic [2:0] ENC_U32BE   = 3'd4;
    localparam logic [2:0] ENC_UCS2LE  = 3'd5;
    localparam logic [2:0] ENC_UCS2BE  = 3'd6;

    // Result status codes; ST_DATA also means "no stop" inside the decoder
    localparam logic [2:0] ST_DATA     = 3'd0;
    localparam logic [2:0] ST_END      = 3'd1;
    localparam logic [2:0] ST_ZERO     = 3'd2;
    localparam logic [2:0] ST_INVALID  = 3'd3;
    localparam logic [2:0] ST_TRUNC    = 3'd4;

    localparam int MAX_DATA = 6;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic [2:0]  status;
        logic [31:0] byte_total;
        logic        run_last;
    } out_item_t;

    // Decoder state carried from byte to byte
    typedef struct packed {
        logic [2:0]  pend;
        logic [30:0] acc;
        logic        discarding;
        logic [31:0] count;
    } dec_state_t;

    // All results caused by one input byte
    typedef struct packed {
        logic [MAX_DATA-1:0][7:0] data;
        logic [2:0]               n_data;
        logic [2:0]               n_total;
        logic [2:0]               stat;
        logic [31:0]              total;
    } job_t;

endpackage

>>> rtl/utf8t_dec.sv
// Per-byte UTF-8 decode, re-encode and buffer bookkeeping.
module utf8t_dec (
    input  logic [2:0]           target,
    input  utf8t_pkg::in_item_t  item,
    input  utf8t_pkg::dec_state_t st,
    output utf8t_pkg::dec_state_t st_next,
    output utf8t_pkg::job_t      job
);

    logic [2:0]       lead_cnt;
    logic [6:0]       lead_h;
    logic [30:0]      acc_shift;
    logic [30:0]      cp;
    logic             do_enc;
    logic [2:0]       stop;
    logic [2:0]       enc_n;
    logic [utf8t_pkg::MAX_DATA-1:0][7:0] enc_b;
    logic [5:0][5:0]  grp;
    logic [30:0]      v;
    logic [15:0]      hi_u;
    logic [15:0]      lo_u;
    logic             be;
    logic             ucs;
    logic [2:0]       n_data;
    logic [32:0]      sum;
    logic [31:0]      cnt_sat;

    // Lead byte classification
    always_comb
    begin
        priority if (!item.in_byte[7])
        begin
            lead_cnt = 3'd1;
            lead_h   = item.in_byte[6:0];
        end
        else if (item.in_byte[7:5] == 3'b110)
        begin
            lead_cnt = 3'd2;
            lead_h   = {2'b00, item.in_byte[4:0]};
        end
        else if (item.in_byte[7:4] == 4'b1110)
        begin
            lead_cnt = 3'd3;
            lead_h   = {3'b000, item.in_byte[3:0]};
        end
        else if (item.in_byte[7:3] == 5'b11110)
        begin
            lead_cnt = 3'd4;
            lead_h   = {4'b0000, item.in_byte[2:0]};
        end
        else if (item.in_byte[7:2] == 6'b111110)
        begin
            lead_cnt = 3'd5;
            lead_h   = {5'b00000, item.in_byte[1:0]};
        end
        else if (item.in_byte[7:1] == 7'b1111110)
        begin
            lead_cnt = 3'd6;
            lead_h   = {6'b000000, item.in_byte[0]};
        end
        else
        begin
            lead_cnt = 3'd0;
            lead_h   = '0;
        end
    end

    assign acc_shift = {st.acc[24:0], item.in_byte[5:0]};

    // Code point re-encoding
    assign grp[0] = cp[5:0];
    assign grp[1] = cp[11:6];
    assign grp[2] = cp[17:12];
    assign grp[3] = cp[23:18];
    assign grp[4] = cp[29:24];
    assign grp[5] = {5'b00000, cp[30]};

    assign v    = cp - 31'h10000;
    assign hi_u = 16'hd800 + v[25:10];
    assign lo_u = 16'hdc00 | {6'b000000, v[9:0]};
    assign be   = (target == utf8t_pkg::ENC_U16BE) || (target == utf8t_pkg::ENC_UCS2BE);
    assign ucs  = (target == utf8t_pkg::ENC_UCS2LE) || (target == utf8t_pkg::ENC_UCS2BE);

    always_comb
    begin
        logic [2:0] gi;
        enc_b = '0;
        enc_n = 3'd0;
        gi    = 3'd0;
        unique case (target)
            utf8t_pkg::ENC_U16LE, utf8t_pkg::ENC_U16BE,
            utf8t_pkg::ENC_UCS2LE, utf8t_pkg::ENC_UCS2BE:
            begin
                if (cp < 31'h10000)
                begin
                    enc_n    = 3'd2;
                    enc_b[0] = be ? cp[15:8] : cp[7:0];
                    enc_b[1] = be ? cp[7:0]  : cp[15:8];
                end
                else if (!ucs)
                begin
                    enc_n    = 3'd4;
                    enc_b[0] = be ? hi_u[15:8] : hi_u[7:0];
                    enc_b[1] = be ? hi_u[7:0]  : hi_u[15:8];
                    enc_b[2] = be ? lo_u[15:8] : lo_u[7:0];
                    enc_b[3] = be ? lo_u[7:0]  : lo_u[15:8];
                end
            end
            utf8t_pkg::ENC_U32LE:
            begin
                enc_n    = 3'd4;
                enc_b[0] = cp[7:0];
                enc_b[1] = cp[15:8];
                enc_b[2] = cp[23:16];
                enc_b[3] = {1'b0, cp[30:24]};
            end
            utf8t_pkg::ENC_U32BE:
            begin
                enc_n    = 3'd4;
                enc_b[0] = {1'b0, cp[30:24]};
                enc_b[1] = cp[23:16];
                enc_b[2] = cp[15:8];
                enc_b[3] = cp[7:0];
            end
            default:
            begin
                // UTF-8, also for the unused selector code
                priority if (cp <= 31'h7f)
                begin
                    enc_n    = 3'd1;
                    enc_b[0] = cp[7:0];
                end
                else if (cp <= 31'h7ff)
                begin
                    enc_n    = 3'd2;
                    enc_b[0] = 8'hc0 | cp[13:6];
                end
                else if (cp <= 31'hffff)
                begin
                    enc_n    = 3'd3;
                    enc_b[0] = 8'he0 | cp[19:12];
                end
                else if (cp <= 31'h1fffff)
                begin
                    enc_n    = 3'd4;
                    enc_b[0] = 8'hf0 | cp[25:18];
                end
                else if (cp <= 31'h3ffffff)
                begin
                    enc_n    = 3'd5;
                    enc_b[0] = 8'hf8 | {1'b0, cp[30:24]};
                end
                else
                begin
                    enc_n    = 3'd6;
                    enc_b[0] = {7'b1111110, cp[30]};
                end
                // continuation bytes, most significant group first
                for (int j = 1; j < utf8t_pkg::MAX_DATA; j++)
                begin
                    if (3'(j) < enc_n)
                    begin
                        gi       = enc_n - 3'(j) - 3'd1;
                        enc_b[j] = {2'b10, grp[gi]};
                    end
                end
            end
        endcase
    end

    // Sequence tracking and stop decisions
    always_comb
    begin
        st_next = st;
        stop    = utf8t_pkg::ST_DATA;
        do_enc  = 1'b0;
        cp      = '0;
        if (!st.discarding)
        begin
            if (st.pend == 3'd0)
            begin
                if (lead_cnt == 3'd0)
                begin
                    stop = utf8t_pkg::ST_INVALID;
                end
                else if (lead_cnt == 3'd1)
                begin
                    if (lead_h == 7'd0)
                    begin
                        stop = utf8t_pkg::ST_ZERO;
                    end
                    else
                    begin
                        do_enc = 1'b1;
                        cp     = 31'(lead_h);
                    end
                end
                else
                begin
                    st_next.pend = lead_cnt - 3'd1;
                    st_next.acc  = 31'(lead_h);
                end
            end
            else if (item.in_byte[7:6] != 2'b10)
            begin
                stop = utf8t_pkg::ST_INVALID;
            end
            else
            begin
                st_next.pend = st.pend - 3'd1;
                st_next.acc  = acc_shift;
                if (st.pend == 3'd1)
                begin
                    st_next.acc = '0;
                    if (acc_shift == 31'd0)
                    begin
                        stop = utf8t_pkg::ST_ZERO;
                    end
                    else
                    begin
                        do_enc = 1'b1;
                        cp     = acc_shift;
                    end
                end
            end
        end

        if (!st.discarding && stop == utf8t_pkg::ST_DATA && item.in_last
            && st_next.pend != 3'd0)
        begin
            stop = utf8t_pkg::ST_TRUNC;
        end

        n_data  = do_enc ? enc_n : 3'd0;
        sum     = {1'b0, st.count} + 33'(n_data);
        cnt_sat = sum[32] ? 32'hffffffff : sum[31:0];

        job.data    = enc_b;
        job.n_data  = n_data;
        job.total   = cnt_sat;
        job.stat    = stop;
        job.n_total = n_data;

        if (st.discarding)
        begin
            job.n_total = 3'd0;
            if (item.in_last)
            begin
                st_next = '0;
            end
        end
        else
        begin
            st_next.count = cnt_sat;
            if (stop != utf8t_pkg::ST_DATA)
            begin
                job.n_total = n_data + 3'd1;
                if (item.in_last)
                begin
                    st_next = '0;
                end
                else
                begin
                    st_next.pend       = '0;
                    st_next.acc        = '0;
                    st_next.discarding = 1'b1;
                end
            end
            else if (item.in_last)
            begin
                job.stat    = utf8t_pkg::ST_END;
                job.n_total = n_data + 3'd1;
                st_next     = '0;
            end
        end
    end

endmodule

>>> rtl/utf8_transcoder_top.sv
// Top level of the UTF-8 to UTF-8/UTF-16/UTF-32/UCS-2 transcoder.
// A byte waits in the input stage until its job is loaded into the result stage.
// Throughput: one byte per cycle while out_stall is low and each byte gives
// at most one result; otherwise the one-byte port passes its results (up to seven).
// Reset (rst_n low, asynchronous) empties both stages and clears the decoder state.
module utf8_transcoder_top (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [2:0]           cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  utf8t_pkg::in_item_t  in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output utf8t_pkg::out_item_t out_data
);

    logic [2:0]            target_reg;
    logic                  a_valid_reg;
    utf8t_pkg::in_item_t   a_item_reg;
    utf8t_pkg::dec_state_t st_reg;
    utf8t_pkg::dec_state_t st_next;
    utf8t_pkg::job_t       job_reg;
    utf8t_pkg::job_t       job_next;
    logic                  job_valid_reg;
    logic [2:0]            idx_reg;

    logic                  out_fire;
    logic                  out_last;
    logic                  job_free;
    logic                  take;
    logic                  is_data;

    // Configuration is always ready; user writes must arrive only while idle
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= utf8t_pkg::ENC_UTF8;
        end
        else if (cfg_valid)
        begin
            target_reg <= cfg_data;
        end
    end

    // Result stage: walk the stored job one result per transaction
    assign out_valid = job_valid_reg;
    assign out_last  = (idx_reg == job_reg.n_total - 3'd1);
    assign out_fire  = job_valid_reg && !out_stall;
    assign is_data   = (idx_reg < job_reg.n_data);

    always_comb
    begin
        out_data.out_byte   = is_data ? job_reg.data[idx_reg] : 8'h00;
        out_data.status     = is_data ? utf8t_pkg::ST_DATA : job_reg.stat;
        out_data.byte_total = is_data ? 32'd0 : job_reg.total;
        out_data.run_last   = out_last;
    end

    // Result stage frees up when empty or when its final result leaves now
    assign job_free = !job_valid_reg || (out_fire && out_last);

    // Input stage: hold the byte until the result stage can take its job
    assign take     = a_valid_reg && job_free;
    assign in_stall = a_valid_reg && !job_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (in_valid && !in_stall)
        begin
            a_valid_reg <= 1'b1;
        end
        else if (take)
        begin
            a_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            a_item_reg <= in_data;
        end
    end

    utf8t_dec u_dec (
        .target  (target_reg),
        .item    (a_item_reg),
        .st      (st_reg),
        .st_next (st_next),
        .job     (job_next)
    );

    // Advance decoder state as each byte leaves the input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= '0;
        end
        else if (take)
        begin
            st_reg <= st_next;
        end
    end

    // Load a job only when the byte causes results; drop empty ones
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            idx_reg       <= 3'd0;
        end
        else if (take)
        begin
            job_valid_reg <= (job_next.n_total != 3'd0);
            idx_reg       <= 3'd0;
        end
        else if (out_fire)
        begin
            if (out_last)
            begin
                job_valid_reg <= 1'b0;
                idx_reg       <= 3'd0;
            end
            else
            begin
                idx_reg <= idx_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            job_reg <= job_next;
        end
    end

`ifndef SYNTHESIS
    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        job_valid_reg |-> (idx_reg < job_reg.n_total))
        else $error("result index beyond job length");

    a_job_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && out_last && !take) |=> !out_valid)
        else $error("result stage still valid after final result");

    a_discard_clean: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.discarding |-> (st_reg.pend == 3'd0 && st_reg.acc == 31'd0))
        else $error("discarding with a sequence still open");

    a_job_limit: assert property (@(posedge clk) disable iff (!rst_n)
        job_valid_reg |-> (job_reg.n_total <= job_reg.n_data + 3'd1))
        else $error("job holds more than one status result");

    a_status_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.status != utf8t_pkg::ST_DATA) |-> out_data.run_last)
        else $error("status result not last of its byte");
`endif

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the UTF-8 transcoder: directed and random byte streams.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    // Selector value outside the named encodings; the block treats it as UTF-8.
    localparam logic [2:0] ENC_SEL7 = 3'd7;

    // Cycles to let pass after the last due result; a byte passes the input stage
    // and then the result stage, so this covers bytes that give none.
    localparam int SETTLE_CYCLES = 8;

    // Hard stop for a hung run, far beyond the slowest correct run.
    localparam int TIMEOUT_NS = 2_000_000;

    localparam int MAX_REPORTS = 10;

    // ------------------------------------------------------------------
    // Clock, reset and the block's inputs, all known from time zero
    // ------------------------------------------------------------------
    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [2:0]           cfg_data = utf8t_pkg::ENC_UTF8;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    utf8t_pkg::in_item_t  in_data = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    utf8t_pkg::out_item_t out_data;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    utf8_transcoder_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // ------------------------------------------------------------------
    // Transcoder prediction: its own copy of the decoder state
    // ------------------------------------------------------------------
    logic [2:0]  target_enc = utf8t_pkg::ENC_UTF8;
    logic [2:0]  dec_pend = '0;      // continuation bytes still expected
    logic [30:0] dec_acc = '0;       // code point bits gathered so far
    logic        dec_discard = 1'b0; // buffer stopped, skip up to the end flag
    logic [31:0] dec_count = '0;     // data bytes emitted in this buffer

    utf8t_pkg::out_item_t byte_results[$]; // results of the byte being predicted
    utf8t_pkg::out_item_t due_results[$];  // results still to come from the block

    // Run bookkeeping
    bit          steady = 1'b0;      // suppress idling on both sides
    int          bad_results = 0;
    int          bytes_sent = 0;
    int          buffers_sent = 0;
    int          settings_used = 0;
    int          results_checked = 0;
    int          status_checked = 0;
    utf8t_pkg::out_item_t next_due;

    function automatic void clear_buffer_state();
        dec_pend = '0;
        dec_acc = '0;
        dec_discard = 1'b0;
        dec_count = '0;
    endfunction

    function automatic void push_result(input logic [7:0] b, input logic [2:0] st,
                                        input logic [31:0] total);
        utf8t_pkg::out_item_t r;
        r.out_byte = b;
        r.status = st;
        r.byte_total = total;
        r.run_last = 1'b0;
        byte_results = {byte_results, r};
    endfunction

    // Emit one data byte and advance the saturating count.
    function automatic void push_data(input logic [7:0] b);
        push_result(b, utf8t_pkg::ST_DATA, 32'd0);
        if (dec_count != 32'hFFFF_FFFF)
            dec_count = dec_count + 32'd1;
    endfunction

    // Re-encode one completed code point in the current target encoding.
    function automatic void encode_point(input logic [31:0] cp);
        int          len;
        int          i;
        logic [7:0]  mask;
        logic [31:0] part;
        logic [31:0] v;
        logic [15:0] units [2];
        int          n_units;
        bit          big_end;
        bit          ucs;
        if (target_enc == utf8t_pkg::ENC_U32LE || target_enc == utf8t_pkg::ENC_U32BE)
        begin
            for (i = 0; i < 4; i++)
            begin
                part = cp >> ((target_enc == utf8t_pkg::ENC_U32LE) ? 8 * i : 8 * (3 - i));
                push_data(part[7:0]);
            end
        end
        else if (target_enc == utf8t_pkg::ENC_U16LE || target_enc == utf8t_pkg::ENC_U16BE ||
                 target_enc == utf8t_pkg::ENC_UCS2LE || target_enc == utf8t_pkg::ENC_UCS2BE)
        begin
            big_end = (target_enc == utf8t_pkg::ENC_U16BE ||
                       target_enc == utf8t_pkg::ENC_UCS2BE);
            ucs = (target_enc == utf8t_pkg::ENC_UCS2LE || target_enc == utf8t_pkg::ENC_UCS2BE);
            if (cp < 32'h1_0000)
            begin
                units[0] = cp[15:0];
                n_units = 1;
            end
            else
            begin
                // UCS-2 has no way to carry points above the BMP: drop them
                if (ucs)
                    return;
                v = cp - 32'h1_0000;
                // high surrogate keeps only its low 16 bits for huge points
                part = 32'hD800 + (v >> 10);
                units[0] = part[15:0];
                units[1] = 16'hDC00 + {6'd0, v[9:0]};
                n_units = 2;
            end
            for (i = 0; i < n_units; i++)
            begin
                push_data(big_end ? units[i][15:8] : units[i][7:0]);
                push_data(big_end ? units[i][7:0] : units[i][15:8]);
            end
        end
        else
        begin
            // UTF-8, also for selector seven
            if (cp <= 32'h7F)
            begin
                push_data(cp[7:0]);
                return;
            end
            if (cp <= 32'h0000_07FF)
            begin
                len = 2;
                mask = 8'hC0;
            end
            else if (cp <= 32'h0000_FFFF)
            begin
                len = 3;
                mask = 8'hE0;
            end
            else if (cp <= 32'h001F_FFFF)
            begin
                len = 4;
                mask = 8'hF0;
            end
            else if (cp <= 32'h03FF_FFFF)
            begin
                len = 5;
                mask = 8'hF8;
            end
            else
            begin
                len = 6;
                mask = 8'hFC;
            end
            part = {24'd0, mask} | (cp >> (6 * (len - 1)));
            push_data(part[7:0]);
            for (i = len - 2; i >= 0; i--)
            begin
                part = cp >> (6 * i);
                push_data({2'b10, part[5:0]});
            end
        end
    endfunction

    // Predict every result one accepted source byte causes and queue them.
    function automatic void transcode_byte(input logic [7:0] b, input logic last);
        logic [2:0]  stop;
        int          cnt;
        logic [30:0] head;
        utf8t_pkg::out_item_t r;
        byte_results.delete();
        if (dec_discard)
        begin
            if (last)
                clear_buffer_state();
            return;
        end
        stop = utf8t_pkg::ST_DATA;
        cnt = 0;
        head = '0;
        if (dec_pend == 3'd0)
        begin
            if (b[7] == 1'b0)
            begin
                cnt = 1;
                head = {23'd0, b};
            end
            else if (b[7:5] == 3'b110)
            begin
                cnt = 2;
                head = {26'd0, b[4:0]};
            end
            else if (b[7:4] == 4'b1110)
            begin
                cnt = 3;
                head = {27'd0, b[3:0]};
            end
            else if (b[7:3] == 5'b11110)
            begin
                cnt = 4;
                head = {28'd0, b[2:0]};
            end
            else if (b[7:2] == 6'b111110)
            begin
                cnt = 5;
                head = {29'd0, b[1:0]};
            end
            else if (b[7:1] == 7'b1111110)
            begin
                cnt = 6;
                head = {30'd0, b[0]};
            end
            else
                stop = utf8t_pkg::ST_INVALID;
            if (cnt == 1)
            begin
                if (head == '0)
                    stop = utf8t_pkg::ST_ZERO;
                else
                    encode_point({1'b0, head});
            end
            else if (cnt > 1)
            begin
                dec_pend = 3'(cnt - 1);
                dec_acc = head;
            end
        end
        else if (b[7:6] != 2'b10)
            stop = utf8t_pkg::ST_INVALID;
        else
        begin
            dec_acc = {dec_acc[24:0], b[5:0]};
            dec_pend = dec_pend - 3'd1;
            if (dec_pend == 3'd0)
            begin
                if (dec_acc == '0)
                    stop = utf8t_pkg::ST_ZERO;
                else
                    encode_point({1'b0, dec_acc});
                dec_acc = '0;
            end
        end
        if (stop == utf8t_pkg::ST_DATA && last && dec_pend != 3'd0)
            stop = utf8t_pkg::ST_TRUNC;
        if (stop != utf8t_pkg::ST_DATA)
        begin
            push_result(8'd0, stop, dec_count);
            if (last)
                clear_buffer_state();
            else
            begin
                dec_pend = '0;
                dec_acc = '0;
                dec_discard = 1'b1;
            end
        end
        else if (last)
        begin
            push_result(8'd0, utf8t_pkg::ST_END, dec_count);
            clear_buffer_state();
        end
        if (byte_results.size() > 0)
        begin
            r = byte_results[byte_results.size() - 1];
            r.run_last = 1'b1;
            byte_results[byte_results.size() - 1] = r;
        end
        foreach (byte_results[k])
            due_results = {due_results, byte_results[k]};
    endfunction

    // ------------------------------------------------------------------
    // Result checking and receiver stalls
    // ------------------------------------------------------------------
    function automatic void report_bad_result(input string what,
                                              input utf8t_pkg::out_item_t got,
                                              input utf8t_pkg::out_item_t want);
        bad_results++;
        if (bad_results <= MAX_REPORTS)
        begin
            $display("%0t %s: got byte %02h status %0d total %0d last %0b",
                     $realtime, what, got.out_byte, got.status, got.byte_total,
                     got.run_last);
            $display("    expected byte %02h status %0d total %0d last %0b",
                     want.out_byte, want.status, want.byte_total, want.run_last);
        end
    endfunction

    // Sample at the edge: out_stall read here is the value the block saw,
    // the new stall decision only lands after this edge.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            results_checked++;
            if (out_data.status != utf8t_pkg::ST_DATA)
                status_checked++;
            if (due_results.size() == 0)
                report_bad_result("unexpected result", out_data, '0);
            else
            begin
                next_due = due_results.pop_front();
                if (out_data.out_byte !== next_due.out_byte ||
                    out_data.status !== next_due.status ||
                    out_data.byte_total !== next_due.byte_total ||
                    out_data.run_last !== next_due.run_last)
                    report_bad_result("result mismatch", out_data, next_due);
            end
        end
        out_stall <= !steady && ($urandom_range(0, 99) < 13);
    end

    // ------------------------------------------------------------------
    // Shared stimulus tasks; each returns right after a rising edge
    // ------------------------------------------------------------------

    // Offer one source byte, hold it until accepted, then predict its results.
    task automatic send_byte(input logic [7:0] b, input logic last);
        utf8t_pkg::in_item_t item;
        int                  gap;
        if (!steady && $urandom_range(0, 99) < 13)
        begin
            gap = $urandom_range(1, 4);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item.in_byte = b;
        item.in_last = last;
        in_valid <= 1'b1;
        in_data <= item;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        transcode_byte(b, last);
        bytes_sent++;
    endtask

    // Drop valid and hold off until every due result has come back.
    task automatic wait_drain();
        in_valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write the target encoding register while the block is idle.
    task automatic set_encoding(input logic [2:0] enc);
        wait_drain();
        cfg_valid <= 1'b1;
        cfg_data <= enc;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        target_enc = enc;
        settings_used++;
    endtask

    // Random lead byte for a sequence of the given length.
    function automatic logic [7:0] lead_byte(input int len);
        logic [7:0] r;
        r = 8'($urandom_range(0, 255));
        unique case (len)
            1: lead_byte = 8'($urandom_range(1, 127));
            2: lead_byte = {3'b110, r[4:0]};
            3: lead_byte = {4'b1110, r[3:0]};
            4: lead_byte = {5'b11110, r[2:0]};
            5: lead_byte = {6'b111110, r[1:0]};
            default: lead_byte = {7'b1111110, r[0]};
        endcase
    endfunction

    // One source buffer: mostly well-formed sequences with random content,
    // some noise bytes, cut sequences and zero code points; the end flag on the last byte.
    task automatic send_random_buffer();
        logic [7:0] seq[$];
        logic [7:0] r;
        int         n_points;
        int         kind;
        int         len;
        int         k;
        int         j;
        n_points = $urandom_range(1, 6);
        for (k = 0; k < n_points; k++)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 80)
            begin
                r = 8'($urandom_range(0, 99));
                len = (r < 40) ? 1 : (r < 60) ? 2 : (r < 74) ? 3 :
                      (r < 86) ? 4 : (r < 93) ? 5 : 6;
                seq = {seq, lead_byte(len)};
                for (j = 1; j < len; j++)
                begin
                    r = 8'($urandom_range(0, 63));
                    seq = {seq, {2'b10, r[5:0]}};
                end
            end
            else if (kind < 88)
                seq = {seq, 8'($urandom_range(0, 255))};
            else if (kind < 94)
            begin
                len = $urandom_range(2, 6);
                seq = {seq, lead_byte(len)};
                repeat ($urandom_range(0, len - 2))
                begin
                    r = 8'($urandom_range(0, 63));
                    seq = {seq, {2'b10, r[5:0]}};
                end
            end
            else if ($urandom_range(0, 1) == 0)
                seq = {seq, 8'h00};
            else
            begin
                // overlong form of zero
                seq = {seq, 8'hC0};
                seq = {seq, 8'h80};
            end
        end
        for (j = 0; j < seq.size(); j++)
            send_byte(seq[j], j == seq.size() - 1);
        buffers_sent++;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes, the UTF-8, UTF-16 and UCS-2 targets and each stop and end case.
    task automatic test_directed();
        set_encoding(utf8t_pkg::ENC_UTF8);
        send_byte(8'h7F, 1'b0);
        // largest six-byte point, re-encoded as six bytes
        send_byte(8'hFD, 1'b0);
        repeat (4) send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b1);

        // five-byte point: high surrogate wraps to 16 bits
        set_encoding(utf8t_pkg::ENC_U16BE);
        send_byte(8'hFB, 1'b0);
        repeat (3) send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b1);

        // UCS-2 drops a point above the BMP, then a clean end
        set_encoding(utf8t_pkg::ENC_UCS2LE);
        send_byte(8'hF0, 1'b0);
        send_byte(8'h90, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b1);
        // overlong zero stops the buffer; discard through the end flag
        send_byte(8'hC0, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        // stray continuation and bad lead, each on the flagged byte
        send_byte(8'h80, 1'b1);
        send_byte(8'hFE, 1'b1);
        // non-continuation where one is due
        send_byte(8'hE2, 1'b0);
        send_byte(8'h41, 1'b1);
        // short tail
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b1);
        // plain zero
        send_byte(8'h00, 1'b1);
    endtask

    // Pause mid-sequence until the block has nothing left, then finish it.
    task automatic test_pause_on_drain();
        set_encoding(utf8t_pkg::ENC_U32LE);
        send_byte(8'h41, 1'b0);
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b0);
        wait_drain();
        send_byte(8'hAC, 1'b1);
    endtask

    // Random buffers under every selector value, extremes included.
    task automatic test_random_sweep();
        logic [2:0] encs [8];
        int         goal;
        int         p;
        encs = '{utf8t_pkg::ENC_UTF8, utf8t_pkg::ENC_U16LE, utf8t_pkg::ENC_U16BE,
                 utf8t_pkg::ENC_U32LE, utf8t_pkg::ENC_U32BE, utf8t_pkg::ENC_UCS2LE,
                 utf8t_pkg::ENC_UCS2BE, ENC_SEL7};
        for (p = 0; p < 8; p++)
        begin
            set_encoding(encs[p]);
            goal = bytes_sent + 44;
            while (bytes_sent < goal)
                send_random_buffer();
        end
    endtask

    // Long stretch at full rate on the widest expansion, no idling anywhere.
    task automatic test_steady_stream();
        int goal;
        set_encoding(utf8t_pkg::ENC_U32BE);
        steady = 1'b1;
        goal = bytes_sent + 48;
        while (bytes_sent < goal)
            send_random_buffer();
        wait_drain();
        steady = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Run sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_pause_on_drain();
        test_random_sweep();
        test_steady_stream();

        // Let the last results come out, then allow for anything stray.
        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (due_results.size() != 0)
            bad_results++;

        $display("Summary: %0d source bytes, %0d random buffers, %0d register writes",
                 bytes_sent, buffers_sent, settings_used);
        $display("Summary: %0d results checked, %0d of them status, %0d bad",
                 results_checked, status_checked, bad_results);
        if (bad_results == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("Timeout with %0d results still due", due_results.size());
        $display("tb_top failed");
        $finish;
    end

endmodule

>>> files.f
rtl/utf8t_pkg.sv
rtl/utf8t_dec.sv
rtl/utf8_transcoder_top.sv
tb/tb_top.sv
